// ----- rtl/gbfd_pkg.sv -----
// ---------------------------------------------------------------------------
// gbfd_pkg
// Shared types and constants for the binary GNSS frame deframer.
// ---------------------------------------------------------------------------
package gbfd_pkg;

	localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND   = 8'h62;
	localparam logic [15:0] MAX_LEN_RESET = 16'd64;

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CHECK_A = 4'd7,
		PH_CHECK_B = 4'd8
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD   = 1'b0,
		KIND_FRAME_END = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
		logic        frame_good;
	} result_t;

endpackage

// ----- rtl/gbfd_parser.sv -----
// ---------------------------------------------------------------------------
// gbfd_parser
// Frame phase tracking, Fletcher-8 sums and result formation for one word.
// ---------------------------------------------------------------------------
module gbfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_write,
	input  logic [15:0]       cfg_data,
	output logic              res_valid,
	output gbfd_pkg::result_t res
);
	import gbfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [15:0] count_q, count_d;
	logic [15:0] length_q, length_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] max_len_q;
	logic [7:0]  acc_a;
	logic [7:0]  acc_b;
	logic [15:0] len_full;
	logic [15:0] count_inc;

	assign acc_a     = sum_a_q + rx_byte;
	assign acc_b     = sum_b_q + acc_a;
	assign len_full  = {rx_byte, length_q[7:0]};
	assign count_inc = count_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		count_d  = count_q;
		length_d = length_q;
		class_d  = class_q;
		id_d     = id_q;
		case (phase_q)
			PH_SYNC2: begin
				phase_d = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
			end
			PH_CLASS: begin
				class_d = rx_byte;
				sum_a_d = rx_byte;
				sum_b_d = rx_byte;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'd0, rx_byte};
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = len_full;
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				if (len_full == 16'd0) begin
					phase_d = PH_CHECK_A;
				end else if (len_full <= max_len_q) begin
					count_d = 16'd0;
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_PAYLOAD: begin
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = count_inc;
				if (count_inc == length_q) begin
					phase_d = PH_CHECK_A;
				end
			end
			PH_CHECK_A: begin
				phase_d = (rx_byte == sum_a_q) ? PH_CHECK_B : PH_SYNC1;
			end
			PH_CHECK_B: begin
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	always_comb begin
		res_valid        = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.byte_index   = 16'd0;
		res.frame_class  = class_q;
		res.frame_id     = id_q;
		res.frame_length = length_q;
		res.frame_good   = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
			end
			PH_CHECK_A: begin
				res_valid = (rx_byte != sum_a_q);
				res.kind  = KIND_FRAME_END;
			end
			PH_CHECK_B: begin
				res_valid      = 1'b1;
				res.kind       = KIND_FRAME_END;
				res.frame_good = (rx_byte == sum_b_q);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
			count_q  <= 16'd0;
			length_q <= 16'd0;
			class_q  <= 8'd0;
			id_q     <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			count_q  <= count_d;
			length_q <= length_d;
			class_q  <= class_d;
			id_q     <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write) begin
			max_len_q <= cfg_data;
		end
	end

`ifndef SYNTH
	a_end_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_FRAME_END) |->
		(phase_q == PH_CHECK_A || phase_q == PH_CHECK_B))
		else $error("frame end outside checksum phase");
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (count_q < length_q))
		else $error("payload index beyond frame length");
	a_check_b_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_CHECK_B) |=> (phase_q == PH_SYNC1))
		else $error("no return to hunting after checksum");
	a_payload_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_LEN_HI && phase_d == PH_PAYLOAD) |->
		(len_full != 16'd0 && len_full <= max_len_q))
		else $error("payload entered with length over limit");
`endif

endmodule

// ----- rtl/gbfd_out_stage.sv -----
// ---------------------------------------------------------------------------
// gbfd_out_stage
// Result register holding one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module gbfd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gbfd_pkg::result_t res,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              space,
	output gbfd_pkg::result_t res_q
);
	import gbfd_pkg::*;

	logic valid_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- rtl/gbfd_in_stage.sv -----
// ---------------------------------------------------------------------------
// gbfd_in_stage
// Input register for received bytes, advanced when the result side has room.
// ---------------------------------------------------------------------------
module gbfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       step,
	output logic [7:0] byte_s1
);
	logic valid_s1;

	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ----- rtl/gnss_binary_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// gnss_binary_frame_deframer
// Deframes UBX-style binary GNSS frames with a Fletcher-8 check.
// ---------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/rx_byte) takes one received byte per word.
//   out channel (out_valid/out_ready and the result fields) gives one word
//   per payload byte, with its index, and one frame-end word after the
//   checksum (or at a failed first checksum byte) with frame_good.
//   Bytes of sync, header and a good first checksum byte give no word.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes max_payload_length;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A byte is held in the input register, is parsed in one pass and
//   lands in the result register when that register has room.
//   One byte per cycle is sustained while out_ready stays high.
// Reset:
//   Hunting for the first sync byte, limit 64, both registers empty.
// Stall:
//   With out_ready low and a result held, one more byte is taken into the
//   input register; then in_ready falls until the result is taken.
// ---------------------------------------------------------------------------
module gnss_binary_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic [7:0]  frame_class,
	output logic [7:0]  frame_id,
	output logic [15:0] frame_length,
	output logic        frame_good
);
	import gbfd_pkg::*;

	logic       step;
	logic       space;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	assign cfg_ready = 1'b1;

	gbfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (space),
		.step     (step),
		.byte_s1  (byte_s1)
	);

	gbfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	gbfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.space     (space),
		.res_q     (res_q)
	);

	assign result_kind  = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign byte_index   = res_q.byte_index;
	assign frame_class  = res_q.frame_class;
	assign frame_id     = res_q.frame_id;
	assign frame_length = res_q.frame_length;
	assign frame_good   = res_q.frame_good;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary GNSS frame deframer. Directed frames
// cover sync hunting, both checksum failures, zero-length frames and the
// payload limit (reset value, extremes, a write between the length bytes).
// Random frames, broken frames and line noise follow under several limits,
// with random idle bursts on the byte and result channels. Every result
// word is compared field by field against an internal deframing model.
// ---------------------------------------------------------------------------
module tb_top;
	import gbfd_pkg::*;

	typedef enum int {
		FAULT_NONE,
		FAULT_CHECK_A,
		FAULT_CHECK_B,
		FAULT_CUT
	} fault_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data  = 16'h0000;
	logic        out_ready = 1'b1;
	logic        in_ready;
	logic        cfg_ready;
	logic        out_valid;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [15:0] frame_length;
	logic        frame_good;

	phase_t      parse_ph  = PH_SYNC1;
	logic [7:0]  fl_a      = 8'h00;
	logic [7:0]  fl_b      = 8'h00;
	logic [15:0] pay_count = 16'h0000;
	logic [15:0] hdr_len   = 16'h0000;
	logic [7:0]  hdr_class = 8'h00;
	logic [7:0]  hdr_id    = 8'h00;
	logic [15:0] len_limit = MAX_LEN_RESET;

	result_t due_words[$];
	int      mismatch_count = 0;
	int      bytes_sent     = 0;
	int      idle_pct       = 0;
	int      stall_left     = 0;

	always #2 clk = ~clk;

	gnss_binary_frame_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_class  (frame_class),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.frame_good   (frame_good)
	);

	function automatic void push_word(kind_t kind, logic [7:0] data, logic [15:0] idx,
			logic good);
		result_t w;
		w.kind         = kind;
		w.payload_byte = data;
		w.byte_index   = idx;
		w.frame_class  = hdr_class;
		w.frame_id     = hdr_id;
		w.frame_length = hdr_len;
		w.frame_good   = good;
		due_words.push_back(w);
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		case (parse_ph)
			PH_SYNC2: begin
				parse_ph = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
			end
			PH_CLASS: begin
				hdr_class = b;
				fl_a      = b;
				fl_b      = b;
				parse_ph  = PH_ID;
			end
			PH_ID: begin
				hdr_id   = b;
				fl_a     = fl_a + b;
				fl_b     = fl_b + fl_a;
				parse_ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				hdr_len  = {8'h00, b};
				fl_a     = fl_a + b;
				fl_b     = fl_b + fl_a;
				parse_ph = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				hdr_len[15:8] = b;
				fl_a          = fl_a + b;
				fl_b          = fl_b + fl_a;
				if (hdr_len == 16'h0000) begin
					parse_ph = PH_CHECK_A;
				end else if (hdr_len <= len_limit) begin
					pay_count = 16'h0000;
					parse_ph  = PH_PAYLOAD;
				end else begin
					parse_ph = PH_SYNC1;
				end
			end
			PH_PAYLOAD: begin
				fl_a = fl_a + b;
				fl_b = fl_b + fl_a;
				push_word(KIND_PAYLOAD, b, pay_count, 1'b0);
				pay_count = pay_count + 16'd1;
				if (pay_count == hdr_len) begin
					parse_ph = PH_CHECK_A;
				end
			end
			PH_CHECK_A: begin
				if (b == fl_a) begin
					parse_ph = PH_CHECK_B;
				end else begin
					push_word(KIND_FRAME_END, 8'h00, 16'h0000, 1'b0);
					parse_ph = PH_SYNC1;
				end
			end
			PH_CHECK_B: begin
				push_word(KIND_FRAME_END, 8'h00, 16'h0000, b == fl_b);
				parse_ph = PH_SYNC1;
			end
			default: begin
				parse_ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		len_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input fault_t fault, input int fill);
		logic [7:0] hdr [4];
		logic [7:0] sa;
		logic [7:0] sb;
		logic [7:0] d;
		int         cut_at;
		hdr[0] = cls;
		hdr[1] = id;
		hdr[2] = len[7:0];
		hdr[3] = len[15:8];
		sa     = 8'h00;
		sb     = 8'h00;
		cut_at = (fault == FAULT_CUT) ? int'($urandom_range(0, int'(len))) : -1;
		put_byte(SYNC_FIRST);
		put_byte(SYNC_SECOND);
		for (int i = 0; i < 4; i++) begin
			put_byte(hdr[i]);
			sa = sa + hdr[i];
			sb = sb + sa;
		end
		if (len > len_limit) return;
		for (int i = 0; i < int'(len); i++) begin
			if (i == cut_at) return;
			d = (fill < 0) ? 8'($urandom) : fill[7:0];
			put_byte(d);
			sa = sa + d;
			sb = sb + sa;
		end
		if (cut_at == int'(len)) return;
		case (fault)
			FAULT_CHECK_A: begin
				put_byte(sa ^ 8'($urandom_range(1, 255)));
			end
			FAULT_CHECK_B: begin
				put_byte(sa);
				put_byte(sb ^ 8'($urandom_range(1, 255)));
			end
			default: begin
				put_byte(sa);
				put_byte(sb);
			end
		endcase
	endtask

	task automatic send_noise(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 3);
			if (pick == 0) begin
				put_byte(SYNC_FIRST);
			end else if (pick == 1) begin
				put_byte(SYNC_SECOND);
			end else begin
				put_byte(8'($urandom));
			end
		end
	endtask

	task automatic test_sync_hunt();
		put_byte(SYNC_FIRST);
		put_byte(SYNC_FIRST);
		put_byte(SYNC_SECOND);
		put_byte(8'h00);
		put_byte(8'hFF);
		send_frame(8'hFF, 8'h00, 16'd0, FAULT_NONE, 0);
	endtask

	task automatic test_checksum();
		send_frame(8'h00, 8'h00, 16'd0, FAULT_CHECK_A, 0);
		send_frame(8'hFF, 8'hFF, 16'd0, FAULT_CHECK_B, 0);
		send_frame(8'h06, 8'h01, 16'd1, FAULT_NONE, 8'hFF);
		send_frame(8'h06, 8'h01, 16'd1, FAULT_CHECK_B, 8'h00);
	endtask

	task automatic test_reset_limit();
		send_frame(8'h01, 8'h07, MAX_LEN_RESET, FAULT_NONE, -1);
		send_frame(8'h01, 8'h07, MAX_LEN_RESET + 16'd1, FAULT_NONE, -1);
	endtask

	task automatic test_limit_extremes();
		write_limit(16'h0000);
		send_frame(8'h01, 8'h02, 16'd1, FAULT_NONE, 8'h00);
		send_frame(8'h01, 8'h02, 16'd0, FAULT_NONE, 0);
		write_limit(16'hFFFF);
		send_frame(8'h02, 8'h13, 16'd300, FAULT_NONE, -1);
		write_limit(16'd3);
		send_frame(8'h0B, 8'h30, 16'd3, FAULT_NONE, -1);
		send_frame(8'h0B, 8'h30, 16'd4, FAULT_NONE, -1);
	endtask

	task automatic test_limit_mid_frame();
		put_byte(SYNC_FIRST);
		put_byte(SYNC_SECOND);
		put_byte(8'h0A);
		put_byte(8'h05);
		put_byte(8'h02);
		// tighten the limit between the two length bytes: frame must be dropped
		write_limit(16'd1);
		put_byte(8'h00);
		send_frame(8'h0A, 8'h05, 16'd1, FAULT_NONE, 8'hA5);
	endtask

	task automatic test_random(input int n_bytes, input int idle);
		int          start;
		int          pick;
		int          len_max;
		logic [15:0] len;
		fault_t      fault;
		idle_pct = idle;
		start    = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len_max = (len_limit < 16'd24) ? int'(len_limit) : 24;
				if ($urandom_range(0, 19) == 0) begin
					len_max = (len_limit < 16'd200) ? int'(len_limit) : 200;
				end
				len  = 16'($urandom_range(0, len_max));
				pick = $urandom_range(0, 9);
				fault = (pick < 6) ? FAULT_NONE :
					(pick < 7) ? FAULT_CHECK_A :
					(pick < 8) ? FAULT_CHECK_B : FAULT_CUT;
				send_frame(8'($urandom), 8'($urandom), len, fault, -1);
			end else if (pick < 80) begin
				if (len_limit != 16'hFFFF) begin
					send_frame(8'($urandom), 8'($urandom),
						16'($urandom_range(int'(len_limit) + 1, 65535)), FAULT_NONE, -1);
				end
			end else if (pick < 97) begin
				send_noise($urandom_range(1, 8));
			end else begin
				drain();
			end
		end
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_words.size() == 0) begin
				$error("result word with none expected: kind %0b", result_kind);
				mismatch_count++;
			end else begin
				w = due_words.pop_front();
				check_field("result_kind", 16'(w.kind), 16'(result_kind));
				check_field("payload_byte", 16'(w.payload_byte), 16'(payload_byte));
				check_field("byte_index", w.byte_index, byte_index);
				check_field("frame_class", 16'(w.frame_class), 16'(frame_class));
				check_field("frame_id", 16'(w.frame_id), 16'(frame_id));
				check_field("frame_length", w.frame_length, frame_length);
				check_field("frame_good", 16'(w.frame_good), 16'(frame_good));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 25;
		test_sync_hunt();
		test_checksum();
		test_reset_limit();
		test_limit_extremes();
		test_limit_mid_frame();
		write_limit(16'($urandom_range(24, 400)));
		test_random(180, 20);
		write_limit(16'h0000);
		test_random(60, 40);
		write_limit(16'hFFFF);
		test_random(150, 0);
		write_limit(MAX_LEN_RESET);
		test_random(150, 35);
		write_limit(16'($urandom_range(1, 30)));
		test_random(100, 0);
		in_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
